// ----- sv/hal_pkg.sv -----
package hal_pkg;

    localparam int KIND_W   = 2;
    localparam int OBJ_W    = 16;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 2;

    // Request kinds carried on the slave-side tuser.
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture request and start table and stack reads
        logic commit;   // apply the update and load the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free; // output register empty or being drained this cycle
    } t_sts;

endpackage

// ----- sv/hal_ctrl.sv -----
module hal_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  hal_pkg::t_sts i_sts,
    output hal_pkg::t_cmd o_cmd
);

    hal_pkg::t_state r_state;
    hal_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hal_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hal_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = hal_pkg::ST_EXEC;
                end
            end
            hal_pkg::ST_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = hal_pkg::ST_IDLE;
                end
            end
            default: n_state = hal_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            hal_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            hal_pkg::ST_EXEC: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/hal_dp.sv -----
module hal_dp #(
    parameter int MAX_HANDLES = 256,
    parameter int REF_BITS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hal_pkg::t_cmd                 i_cmd,
    output hal_pkg::t_sts                 o_sts,
    input  logic [hal_pkg::KIND_W-1:0]    i_kind,
    input  logic [hal_pkg::OBJ_W-1:0]     i_object_ref,
    input  logic [hal_pkg::HANDLE_W-1:0]  i_handle_in,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [hal_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic [hal_pkg::OBJ_W-1:0]     o_object_out,
    output logic                          o_found,
    output logic [hal_pkg::STATUS_W-1:0]  o_status
);

    // Stored reference width, handle index width, count width and a common
    // compare width wide enough for both the external handle and the counts.
    localparam int RW = (REF_BITS < hal_pkg::OBJ_W) ? REF_BITS : hal_pkg::OBJ_W;
    localparam int HW = $clog2(MAX_HANDLES);
    localparam int CW = $clog2(MAX_HANDLES + 1);
    localparam int XW = (CW > hal_pkg::HANDLE_W) ? CW : hal_pkg::HANDLE_W;

    // Each table word carries a live flag above the reference. Entries at or
    // above the high-water mark were never written and count as not live.
    logic [RW:0]   r_tab_mem [MAX_HANDLES];
    logic [HW-1:0] r_stk_mem [MAX_HANDLES];

    logic [RW:0]                  r_tab_rd;
    logic [HW-1:0]                r_stk_rd;
    logic [hal_pkg::KIND_W-1:0]   r_kind;
    logic [RW-1:0]                r_ref;
    logic [hal_pkg::HANDLE_W-1:0] r_h;
    logic [CW-1:0]                r_free_count;
    logic [CW-1:0]                r_high_water;
    logic                         r_m_tvalid;
    logic [hal_pkg::HANDLE_W-1:0] r_handle_out;
    logic [hal_pkg::OBJ_W-1:0]    r_object_out;
    logic                         r_found;
    logic [hal_pkg::STATUS_W-1:0] r_status;

    logic [CW-1:0]                n_free_count;
    logic [CW-1:0]                n_high_water;
    logic [hal_pkg::HANDLE_W-1:0] n_handle_out;
    logic [hal_pkg::OBJ_W-1:0]    n_object_out;
    logic                         n_found;
    logic [hal_pkg::STATUS_W-1:0] n_status;

    logic [HW-1:0] rd_tab_addr;
    logic [HW-1:0] rd_stk_addr;
    logic [CW-1:0] fc_dec;
    logic [XW-1:0] h_ext;
    logic [HW-1:0] h_idx;
    logic          h_live;
    logic [HW-1:0] grant;
    logic [XW-1:0] grant_ext;
    logic          tab_we;
    logic [HW-1:0] tab_wa;
    logic [RW:0]   tab_wd;
    logic          stk_we;

    assign rd_tab_addr = HW'(XW'(i_handle_in));
    assign fc_dec      = r_free_count - CW'(1);
    assign rd_stk_addr = fc_dec[HW-1:0];

    assign h_ext  = XW'(r_h);
    assign h_idx  = h_ext[HW-1:0];
    assign h_live = (h_ext < XW'(r_high_water)) && r_tab_rd[RW];
    assign grant_ext = XW'(grant);

    always_comb begin
        n_free_count = r_free_count;
        n_high_water = r_high_water;
        n_handle_out = r_h;
        n_object_out = '0;
        n_found      = 1'b0;
        n_status     = hal_pkg::STAT_OK;
        grant        = '0;
        tab_we       = 1'b0;
        tab_wa       = h_idx;
        tab_wd       = {1'b0, r_tab_rd[RW-1:0]};
        stk_we       = 1'b0;
        case (r_kind)
            hal_pkg::KIND_ALLOC: begin
                if (r_free_count != '0) begin
                    grant        = r_stk_rd;
                    n_free_count = fc_dec;
                    tab_we       = 1'b1;
                end else if (r_high_water < CW'(MAX_HANDLES)) begin
                    grant        = r_high_water[HW-1:0];
                    n_high_water = r_high_water + CW'(1);
                    tab_we       = 1'b1;
                end
                if (tab_we) begin
                    tab_wa       = grant;
                    tab_wd       = {1'b1, r_ref};
                    n_handle_out = grant_ext[hal_pkg::HANDLE_W-1:0];
                end else begin
                    n_handle_out = '0;
                    n_status     = hal_pkg::STAT_FULL;
                end
            end
            hal_pkg::KIND_RELEASE: begin
                if (h_live && (r_free_count < CW'(MAX_HANDLES))) begin
                    tab_we       = 1'b1;
                    stk_we       = 1'b1;
                    n_free_count = r_free_count + CW'(1);
                end else begin
                    n_status = hal_pkg::STAT_BAD;
                end
            end
            hal_pkg::KIND_LOOKUP: begin
                if (h_live) begin
                    n_object_out = hal_pkg::OBJ_W'(r_tab_rd[RW-1:0]);
                    n_found      = 1'b1;
                end else begin
                    n_status = hal_pkg::STAT_BAD;
                end
            end
            default: begin
                n_status = hal_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && tab_we) begin
            r_tab_mem[tab_wa] <= tab_wd;
        end
        if (i_cmd.load) begin
            r_tab_rd <= r_tab_mem[rd_tab_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && stk_we) begin
            r_stk_mem[r_free_count[HW-1:0]] <= h_idx;
        end
        if (i_cmd.load) begin
            r_stk_rd <= r_stk_mem[rd_stk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_ref  <= i_object_ref[RW-1:0];
            r_h    <= i_handle_in;
        end
        if (i_cmd.commit) begin
            r_handle_out <= n_handle_out;
            r_object_out <= n_object_out;
            r_found      <= n_found;
            r_status     <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count <= '0;
            r_high_water <= '0;
            r_m_tvalid   <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_free_count <= n_free_count;
                r_high_water <= n_high_water;
                r_m_tvalid   <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid     = r_m_tvalid;
    assign o_handle_out   = r_handle_out;
    assign o_object_out   = r_object_out;
    assign o_found        = r_found;
    assign o_status       = r_status;

endmodule

// ----- sv/handle_allocator_lifo.sv -----
// Handle allocator with a LIFO free list.
// Slave side: one beat is one request. tuser carries the kind (allocate,
// release, look up); tdata carries the object reference and the handle.
// Master side: one beat per request with the granted or echoed handle, the
// stored reference, a found flag and a status code.
// When a request is taken, the handle table and the top of the free stack
// are read into registers; once the output register is free, the registered
// read data decides the result, the table, stack and counters are updated
// and the result is loaded into the output register. No new request is
// taken until the previous one has been loaded into the output register.
// At reset the free count, the high-water mark and the output valid clear;
// no clearing pass runs, since handles at or above the high-water mark are
// treated as not live. When the receiver stalls, the finished result holds
// in the output register, one more request can be taken and read, and it
// then waits until the output register drains.
module handle_allocator_lifo #(
    parameter int MAX_HANDLES = 256,
    parameter int REF_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // object_ref[15:0], handle_in[23:16]
    input  logic [1:0]  i_s_tuser,  // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata   // handle_out[7:0], object_out[23:8],
                                    // found[24], status[26:25], zero[31:27]
);

    hal_pkg::t_cmd cmd;
    hal_pkg::t_sts sts;

    logic [hal_pkg::HANDLE_W-1:0] handle_out;
    logic [hal_pkg::OBJ_W-1:0]    object_out;
    logic                         found;
    logic [hal_pkg::STATUS_W-1:0] status;

    hal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hal_dp #(
        .MAX_HANDLES (MAX_HANDLES),
        .REF_BITS    (REF_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_kind       (i_s_tuser),
        .i_object_ref (i_s_tdata[15:0]),
        .i_handle_in  (i_s_tdata[23:16]),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_handle_out (handle_out),
        .o_object_out (object_out),
        .o_found      (found),
        .o_status     (status)
    );

    assign o_m_tdata = {5'd0, status, found, object_out, handle_out};

endmodule

// ----- verif/handle_allocator_lifo_test.sv -----
`timescale 1ns / 100ps

module handle_allocator_lifo_test;

    localparam int HANDLE_CAP = 256;
    localparam int DIR_ROWS   = 22;
    localparam int RAND_ITEMS = 1150;
    localparam int TOTAL      = DIR_ROWS + RAND_ITEMS;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 20;

    // The request encoding leaves this kind unused; the block echoes the handle.
    localparam logic [hal_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [hal_pkg::KIND_W-1:0]   kind;
        logic [hal_pkg::OBJ_W-1:0]    obj;
        logic [hal_pkg::HANDLE_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [hal_pkg::HANDLE_W-1:0] handle;
        logic [hal_pkg::OBJ_W-1:0]    obj;
        logic                         found;
        logic [hal_pkg::STATUS_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic [hal_pkg::KIND_W-1:0]   kind;
        logic [hal_pkg::OBJ_W-1:0]    obj;
        logic [hal_pkg::HANDLE_W-1:0] handle;
        logic                         chk;
        logic [hal_pkg::HANDLE_W-1:0] e_handle;
        logic [hal_pkg::OBJ_W-1:0]    e_obj;
        logic                         e_found;
        logic [hal_pkg::STATUS_W-1:0] e_status;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;  // object_ref[15:0], handle_in[23:16]
    logic [1:0]  i_s_tuser  = '0;  // kind[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // handle_out[7:0], object_out[23:8],
                                   // found[24], status[26:25], zero[31:27]

    handle_allocator_lifo u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Shadow of the allocator state.
    logic [hal_pkg::OBJ_W-1:0]    obj_table  [HANDLE_CAP];
    logic                         is_live    [HANDLE_CAP];
    logic [hal_pkg::HANDLE_W-1:0] free_stack [HANDLE_CAP];
    logic [8:0]                   free_top;
    logic [8:0]                   water_mark;

    t_result pending_results [$];
    int      fault_count = 0;
    int      items_sent  = 0;
    int      cycles      = 0;
    int      tx_idle_pct = 30;
    int      rx_idle_pct = 54;

    // Directed rows; chk marks rows whose answer is typed in here.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{hal_pkg::KIND_LOOKUP, 16'h0000, 8'h00, 1'b1, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_BAD},
        '{hal_pkg::KIND_RELEASE, 16'h0000, 8'hFF, 1'b1, 8'hFF, 16'h0000, 1'b0, hal_pkg::STAT_BAD},
        '{KIND_UNUSED, 16'hFFFF, 8'hAA, 1'b1, 8'hAA, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_ALLOC, 16'hFFFF, 8'h5C, 1'b1, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_ALLOC, 16'h0000, 8'hFF, 1'b1, 8'h01, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_LOOKUP, 16'h0000, 8'h00, 1'b1, 8'h00, 16'hFFFF, 1'b1, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_LOOKUP, 16'hFFFF, 8'h01, 1'b1, 8'h01, 16'h0000, 1'b1, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_LOOKUP, 16'h0000, 8'h02, 1'b1, 8'h02, 16'h0000, 1'b0, hal_pkg::STAT_BAD},
        '{hal_pkg::KIND_RELEASE, 16'h0000, 8'h00, 1'b1, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_RELEASE, 16'h0000, 8'h00, 1'b1, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_BAD},
        '{hal_pkg::KIND_LOOKUP, 16'h0000, 8'h00, 1'b1, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_BAD},
        '{hal_pkg::KIND_ALLOC, 16'h1234, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_RELEASE, 16'h0000, 8'h01, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_RELEASE, 16'h0000, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_ALLOC, 16'hA5A5, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_ALLOC, 16'h5A5A, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_ALLOC, 16'h8001, 8'hFF, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_LOOKUP, 16'h0000, 8'hFF, 1'b1, 8'hFF, 16'h0000, 1'b0, hal_pkg::STAT_BAD},
        '{KIND_UNUSED, 16'hFFFF, 8'h55, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_LOOKUP, 16'h0000, 8'h02, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_LOOKUP, 16'h0000, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK},
        '{hal_pkg::KIND_RELEASE, 16'h0000, 8'h02, 1'b0, 8'h00, 16'h0000, 1'b0, hal_pkg::STAT_OK}
    };

    function automatic t_result grant_result(input t_req rq);
        t_result                      res;
        logic [hal_pkg::HANDLE_W-1:0] g;
        res = {rq.handle, {hal_pkg::OBJ_W{1'b0}}, 1'b0, hal_pkg::STAT_OK};
        case (rq.kind)
            hal_pkg::KIND_ALLOC: begin
                if (free_top != 0) begin
                    free_top = free_top - 9'd1;
                    g = free_stack[free_top[hal_pkg::HANDLE_W-1:0]];
                end else if (water_mark < HANDLE_CAP) begin
                    g = water_mark[hal_pkg::HANDLE_W-1:0];
                    water_mark = water_mark + 9'd1;
                end else begin
                    res.handle = '0;
                    res.status = hal_pkg::STAT_FULL;
                    return res;
                end
                obj_table[g] = rq.obj;
                is_live[g] = 1'b1;
                res.handle = g;
            end
            hal_pkg::KIND_RELEASE: begin
                if (is_live[rq.handle] && free_top < HANDLE_CAP) begin
                    is_live[rq.handle] = 1'b0;
                    free_stack[free_top[hal_pkg::HANDLE_W-1:0]] = rq.handle;
                    free_top = free_top + 9'd1;
                end else begin
                    res.status = hal_pkg::STAT_BAD;
                end
            end
            hal_pkg::KIND_LOOKUP: begin
                if (is_live[rq.handle]) begin
                    res.obj = obj_table[rq.handle];
                    res.found = 1'b1;
                end else begin
                    res.status = hal_pkg::STAT_BAD;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly a live handle when asked for one and any exist; otherwise any handle.
    function automatic logic [hal_pkg::HANDLE_W-1:0] pick_handle(input bit want_live);
        logic [hal_pkg::HANDLE_W-1:0] h;
        if (want_live && water_mark > free_top) begin
            for (int t = 0; t < 16; t++) begin
                h = hal_pkg::HANDLE_W'($urandom_range(water_mark - 1));
                if (is_live[h])
                    return h;
            end
        end
        return hal_pkg::HANDLE_W'($urandom_range(HANDLE_CAP - 1));
    endfunction

    task automatic send_req(input t_req rq, input bit typed, input t_result typed_res);
        t_result pred;
        if (items_sent < TOTAL / 3) begin
            tx_idle_pct = 30;
            rx_idle_pct = 54;
        end else if (items_sent < 2 * TOTAL / 3) begin
            tx_idle_pct = 54;
            rx_idle_pct = 30;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= rq.kind;
        i_s_tdata  <= {rq.handle, rq.obj};
        do @(posedge i_clk); while (!o_s_tready);
        // The shadow state advances on every beat, typed rows included.
        pred = grant_result(rq);
        pending_results.push_back(typed ? typed_res : pred);
        items_sent++;
    endtask

    task automatic send_kind(input logic [hal_pkg::KIND_W-1:0] kind, input bit want_live);
        t_req rq;
        rq.kind   = kind;
        rq.obj    = hal_pkg::OBJ_W'($urandom);
        rq.handle = pick_handle(want_live);
        send_req(rq, 1'b0, '0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: random back-pressure and in-order comparison.
    t_result got_res;
    t_result want_res;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_res = {o_m_tdata[7:0], o_m_tdata[23:8], o_m_tdata[24], o_m_tdata[26:25]};
            if (pending_results.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result beat: %h", o_m_tdata);
                fault_count++;
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.handle !== want_res.handle || got_res.obj !== want_res.obj ||
                    got_res.found !== want_res.found || got_res.status !== want_res.status ||
                    o_m_tdata[31:27] !== '0) begin
                    if (fault_count < 10)
                        $display("mismatch at cycle %0d: exp h=%h o=%h f=%b s=%0d, got %h",
                                 cycles, want_res.handle, want_res.obj, want_res.found,
                                 want_res.status, o_m_tdata);
                    fault_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        int      burst_kind;
        int      burst_len;
        int      r;
        bit      first_burst;
        t_req    rq;
        t_result typed_res;

        for (int i = 0; i < HANDLE_CAP; i++) begin
            is_live[i] = 1'b0;
            obj_table[i] = '0;
            free_stack[i] = '0;
        end
        free_top = '0;
        water_mark = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            rq = {dir_rows[i].kind, dir_rows[i].obj, dir_rows[i].handle};
            typed_res = {dir_rows[i].e_handle, dir_rows[i].e_obj,
                         dir_rows[i].e_found, dir_rows[i].e_status};
            send_req(rq, dir_rows[i].chk, typed_res);
        end

        first_burst = 1'b1;
        while (items_sent < TOTAL) begin
            burst_kind = first_burst ? 0 : $urandom_range(9);
            first_burst = 1'b0;
            if (burst_kind < 2) begin
                // Fill the table to exhaustion, then knock on the full table.
                while (!(free_top == 0 && water_mark == HANDLE_CAP)) begin
                    if ($urandom_range(9) == 0)
                        send_kind(hal_pkg::KIND_LOOKUP, 1'b1);
                    else
                        send_kind(hal_pkg::KIND_ALLOC, 1'b0);
                end
                repeat ($urandom_range(4, 1)) send_kind(hal_pkg::KIND_ALLOC, 1'b0);
            end else if (burst_kind < 4) begin
                burst_len = $urandom_range(80, 20);
                repeat (burst_len) begin
                    r = $urandom_range(9);
                    if (r == 0)
                        send_kind(hal_pkg::KIND_RELEASE, 1'b0);
                    else if (r == 1)
                        send_kind(hal_pkg::KIND_LOOKUP, 1'b0);
                    else
                        send_kind(hal_pkg::KIND_RELEASE, 1'b1);
                end
            end else begin
                burst_len = $urandom_range(60, 20);
                repeat (burst_len) begin
                    r = $urandom_range(99);
                    if (r < 35)
                        send_kind(hal_pkg::KIND_ALLOC, 1'b0);
                    else if (r < 60)
                        send_kind(hal_pkg::KIND_RELEASE, $urandom_range(99) < 85);
                    else if (r < 92)
                        send_kind(hal_pkg::KIND_LOOKUP, $urandom_range(99) < 75);
                    else
                        send_kind(KIND_UNUSED, 1'b0);
                end
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
